// ----- src/setpoint_step_limiter_3d_top_macros.svh -----
// Assertion macros for the setpoint step limiter.
`ifndef SETPOINT_STEP_LIMITER_3D_TOP_MACROS_SVH
`define SETPOINT_STEP_LIMITER_3D_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SSL3D_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("step limiter check failed");

// next-cycle implication
`define SSL3D_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("step limiter check failed");

`endif

// ----- src/ssl3d_pkg.sv -----
// Shared widths, register codes and reset values of the step limiter.
package ssl3d_pkg;

   localparam int LIMIT_W    = 24;  // step limit, Q8.16
   localparam int LIM2_W     = 25;  // doubled limit
   localparam int THRESH_W   = 31;  // norm threshold
   localparam int MAG_W      = 31;  // axis magnitude after range checks
   localparam int SQ_W       = 62;  // one squared magnitude
   localparam int SUM_W      = 64;  // sum of three squares
   localparam int ROOT_W     = 32;  // floor root of a sum
   localparam int REM_W      = 34;  // root remainder
   localparam int NROOT_W    = 33;  // rounded-up root
   localparam int NUM_W      = 56;  // magnitude times limit
   localparam int QUO_W      = 25;  // scaled magnitude
   localparam int DREM_W     = 33;  // divider remainder
   localparam int LSQ_W      = 50;  // limit squared
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;

   localparam logic [LIMIT_W-1:0]  DEFAULT_LIMIT_RST  = 24'd327680;
   localparam logic [THRESH_W-1:0] NORM_THRESHOLD_RST = 31'd1310720;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEFAULT_LIMIT  = 1'b0,
      CSR_NORM_THRESHOLD = 1'b1
   } csr_index_type;

endpackage

// ----- src/setpoint_step_limiter_3d_top.sv -----
// Setpoint step limiter: pipelined 3D offset clamp and scale to a step limit.
//
// Input channel req_*: a target and a current position (signed, POS_WIDTH bits,
// FRAC_BITS fraction bits) and a requested step limit. A word is taken at a
// clock edge with req_valid high and req_stall low. Result channel rsp_*: the
// limited setpoint, one word per input word, in order, same handshake.
// Configuration port csr_*: write-only, index 0 default step limit, index 1
// norm threshold; write only while no word is in flight.
// The scaling path runs through the 32-stage square root and the 25-stage
// divider. Throughput: one word per cycle while the receiver takes results.
// When rsp_valid is high and rsp_stall is high the whole pipeline holds and
// req_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the
// default register values.
`include "setpoint_step_limiter_3d_top_macros.svh"

module setpoint_step_limiter_3d_top
   import ssl3d_pkg::*;
#(
   parameter int POS_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [POS_WIDTH-1:0]  req_target_x,
   input  logic [POS_WIDTH-1:0]  req_target_y,
   input  logic [POS_WIDTH-1:0]  req_target_z,
   input  logic [POS_WIDTH-1:0]  req_current_x,
   input  logic [POS_WIDTH-1:0]  req_current_y,
   input  logic [POS_WIDTH-1:0]  req_current_z,
   input  logic [LIMIT_W-1:0]    req_requested_limit,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_WIDTH-1:0]  rsp_out_x,
   output logic [POS_WIDTH-1:0]  rsp_out_y,
   output logic [POS_WIDTH-1:0]  rsp_out_z,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PW     = POS_WIDTH;
   localparam int MAGX   = (POS_WIDTH > 32) ? POS_WIDTH : 32;
   localparam int OSUM_W = MAGX + 1;
   localparam int MIN_REQ = ((1 << FRAC_BITS) + 5) / 10;

   typedef struct packed {
      logic [2:0][PW-1:0]    cur;
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0][NUM_W-1:0] num;
      logic                  scale;
   } side_type;

   logic adv;
   logic out_v_ff;

   // pipeline moves unless the output word is held
   assign adv       = !(out_v_ff && rsp_stall);
   assign req_stall = !adv;

   // configuration registers
   logic [LIMIT_W-1:0]  dflt_ff;
   logic [THRESH_W-1:0] thr_ff;
   logic [SQ_W-1:0]     thr_sq_ff;
   logic [SQ_W-1:0]     thr_sq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_ff <= DEFAULT_LIMIT_RST;
         thr_ff  <= NORM_THRESHOLD_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEFAULT_LIMIT:  dflt_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_NORM_THRESHOLD: thr_ff  <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   assign thr_sq_in = SQ_W'(thr_ff) * SQ_W'(thr_ff);
   always_ff @(posedge clock) begin
      thr_sq_ff <= thr_sq_in;
   end

   // stage 1: offsets saturated, limit chosen and doubled
   logic [2:0][PW-1:0] req_t;
   logic [2:0][PW-1:0] req_c;
   logic [2:0][PW:0]   diff;
   logic               s1_v_ff;
   logic [2:0][PW-1:0] s1_cur_ff, s1_d_ff, s1_d_in;
   logic [LIM2_W-1:0]  s1_lim_ff, s1_lim_in;

   assign req_t = {req_target_z, req_target_y, req_target_x};
   assign req_c = {req_current_z, req_current_y, req_current_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = {req_t[i][PW-1], req_t[i]} - {req_c[i][PW-1], req_c[i]};
         if (diff[i][PW] != diff[i][PW-1]) begin
            s1_d_in[i] = {diff[i][PW], {(PW-1){~diff[i][PW]}}};
         end else begin
            s1_d_in[i] = diff[i][PW-1:0];
         end
      end
      if (req_requested_limit < LIMIT_W'(MIN_REQ)) begin
         s1_lim_in = {dflt_ff, 1'b0};
      end else begin
         s1_lim_in = {req_requested_limit, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cur_ff <= req_c;
         s1_d_ff   <= s1_d_in;
         s1_lim_ff <= s1_lim_in;
      end
   end

   // stage 2: magnitudes and per-axis threshold test
   logic [2:0][PW-1:0]    mag_u;
   logic [2:0][MAGX-1:0]  mag_x;
   logic                  s2_v_ff;
   logic [2:0]            s2_neg_ff, s2_big_ff, s2_big_in;
   logic [2:0][MAG_W-1:0] s2_mag_ff, s2_mag_in;
   logic [2:0][PW-1:0]    s2_cur_ff;
   logic [LIM2_W-1:0]     s2_lim_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_u[i] = s1_d_ff[i][PW-1] ? (~s1_d_ff[i] + 1'b1) : s1_d_ff[i];
         mag_x[i] = MAGX'(mag_u[i]);
         s2_big_in[i] = mag_x[i] > MAGX'(thr_ff);
         // too big for the square path: threshold test already fires
         s2_mag_in[i] = (|mag_x[i][MAGX-1:MAG_W]) ? '1 : mag_x[i][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s2_neg_ff[i] <= s1_d_ff[i][PW-1];
         end
         s2_big_ff <= s2_big_in;
         s2_mag_ff <= s2_mag_in;
         s2_cur_ff <= s1_cur_ff;
         s2_lim_ff <= s1_lim_ff;
      end
   end

   // stage 3: squares
   logic                  s3_v_ff, s3_big_ff;
   logic [2:0][SQ_W-1:0]  s3_sq_ff, s3_sq_in;
   logic [2:0]            s3_neg_ff;
   logic [2:0][MAG_W-1:0] s3_mag_ff;
   logic [2:0][PW-1:0]    s3_cur_ff;
   logic [LIM2_W-1:0]     s3_lim_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_sq_in[i] = SQ_W'(s2_mag_ff[i]) * SQ_W'(s2_mag_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_sq_ff  <= s3_sq_in;
         s3_big_ff <= |s2_big_ff;
         s3_neg_ff <= s2_neg_ff;
         s3_mag_ff <= s2_mag_ff;
         s3_cur_ff <= s2_cur_ff;
         s3_lim_ff <= s2_lim_ff;
      end
   end

   // stage 4: sum of squares
   logic                  s4_v_ff, s4_big_ff;
   logic [SUM_W-1:0]      s4_sum_ff, s4_sum_in;
   logic [2:0]            s4_neg_ff;
   logic [2:0][MAG_W-1:0] s4_mag_ff;
   logic [2:0][PW-1:0]    s4_cur_ff;
   logic [LIM2_W-1:0]     s4_lim_ff;

   assign s4_sum_in = SUM_W'(s3_sq_ff[0]) + SUM_W'(s3_sq_ff[1]) + SUM_W'(s3_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_sum_ff <= s4_sum_in;
         s4_big_ff <= s3_big_ff;
         s4_neg_ff <= s3_neg_ff;
         s4_mag_ff <= s3_mag_ff;
         s4_cur_ff <= s3_cur_ff;
         s4_lim_ff <= s3_lim_ff;
      end
   end

   // stage 5: length above threshold
   logic                  s5_v_ff, s5_over_ff, s5_over_in;
   logic [2:0]            s5_neg_ff;
   logic [2:0][MAG_W-1:0] s5_mag_ff;
   logic [2:0][PW-1:0]    s5_cur_ff;
   logic [LIM2_W-1:0]     s5_lim_ff;

   assign s5_over_in = s4_big_ff || (s4_sum_ff > SUM_W'(thr_sq_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_over_ff <= s5_over_in;
         s5_neg_ff  <= s4_neg_ff;
         s5_mag_ff  <= s4_mag_ff;
         s5_cur_ff  <= s4_cur_ff;
         s5_lim_ff  <= s4_lim_ff;
      end
   end

   // stage 6: per-axis clamp to the limit
   logic                  s6_v_ff;
   logic [2:0]            s6_neg_ff;
   logic [2:0][MAG_W-1:0] s6_mag_ff, s6_mag_in;
   logic [2:0][PW-1:0]    s6_cur_ff;
   logic [LIM2_W-1:0]     s6_lim_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s5_over_ff && (s5_mag_ff[i] > MAG_W'(s5_lim_ff))) begin
            s6_mag_in[i] = MAG_W'(s5_lim_ff);
         end else begin
            s6_mag_in[i] = s5_mag_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_mag_ff <= s6_mag_in;
         s6_neg_ff <= s5_neg_ff;
         s6_cur_ff <= s5_cur_ff;
         s6_lim_ff <= s5_lim_ff;
      end
   end

   // stage 7: squares of clamped axes, scale numerators, limit squared
   logic                  s7_v_ff;
   logic [2:0][SQ_W-1:0]  s7_sq_ff, s7_sq_in;
   logic [2:0][NUM_W-1:0] s7_num_ff, s7_num_in;
   logic [LSQ_W-1:0]      s7_lsq_ff, s7_lsq_in;
   logic [2:0]            s7_neg_ff;
   logic [2:0][MAG_W-1:0] s7_mag_ff;
   logic [2:0][PW-1:0]    s7_cur_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_sq_in[i]  = SQ_W'(s6_mag_ff[i]) * SQ_W'(s6_mag_ff[i]);
         s7_num_in[i] = NUM_W'(s6_mag_ff[i]) * NUM_W'(s6_lim_ff);
      end
      s7_lsq_in = LSQ_W'(s6_lim_ff) * LSQ_W'(s6_lim_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_sq_ff  <= s7_sq_in;
         s7_num_ff <= s7_num_in;
         s7_lsq_ff <= s7_lsq_in;
         s7_neg_ff <= s6_neg_ff;
         s7_mag_ff <= s6_mag_ff;
         s7_cur_ff <= s6_cur_ff;
      end
   end

   // stage 8: sum of clamped squares
   logic                  s8_v_ff;
   logic [SUM_W-1:0]      s8_sum_ff, s8_sum_in;
   logic [2:0][NUM_W-1:0] s8_num_ff;
   logic [LSQ_W-1:0]      s8_lsq_ff;
   logic [2:0]            s8_neg_ff;
   logic [2:0][MAG_W-1:0] s8_mag_ff;
   logic [2:0][PW-1:0]    s8_cur_ff;

   assign s8_sum_in = SUM_W'(s7_sq_ff[0]) + SUM_W'(s7_sq_ff[1]) + SUM_W'(s7_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_v_ff <= 1'b0;
      end else if (adv) begin
         s8_v_ff <= s7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_sum_ff <= s8_sum_in;
         s8_num_ff <= s7_num_ff;
         s8_lsq_ff <= s7_lsq_ff;
         s8_neg_ff <= s7_neg_ff;
         s8_mag_ff <= s7_mag_ff;
         s8_cur_ff <= s7_cur_ff;
      end
   end

   // stage 9: scale decision, loads the root pipeline
   logic                  sq_v_ff    [0:ROOT_W];
   logic [REM_W-1:0]      sq_rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0]     sq_root_ff [0:ROOT_W];
   logic [SUM_W-1:0]      sq_bits_ff [0:ROOT_W];
   side_type              sq_side_ff [0:ROOT_W];
   side_type              s9_side_in;

   always_comb begin
      s9_side_in.cur   = s8_cur_ff;
      s9_side_in.neg   = s8_neg_ff;
      s9_side_in.mag   = s8_mag_ff;
      s9_side_in.num   = s8_num_ff;
      s9_side_in.scale = s8_sum_ff > SUM_W'(s8_lsq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= s8_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_bits_ff[0] <= s8_sum_ff;
         sq_side_ff[0] <= s9_side_in;
      end
   end

   // floor square root, one result bit per stage
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      logic [REM_W-1:0]  rem_t, trial, rem_in;
      logic [ROOT_W-1:0] root_in;
      logic              ge;

      assign rem_t   = {sq_rem_ff[k][REM_W-3:0], sq_bits_ff[k][SUM_W-1 -: 2]};
      assign trial   = {sq_root_ff[k], 2'b01};
      assign ge      = rem_t >= trial;
      assign rem_in  = ge ? (rem_t - trial) : rem_t;
      assign root_in = {sq_root_ff[k][ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[k+1]  <= rem_in;
            sq_root_ff[k+1] <= root_in;
            sq_bits_ff[k+1] <= {sq_bits_ff[k][SUM_W-3:0], 2'b00};
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
      end
   end

   // round the root up, load the dividers
   logic                         dv_v_ff   [0:QUO_W];
   logic [NROOT_W-1:0]           dv_n_ff   [0:QUO_W];
   logic [2:0][DREM_W-1:0]       dv_r_ff   [0:QUO_W];
   logic [2:0][QUO_W-1:0]        dv_low_ff [0:QUO_W];
   logic [2:0][QUO_W-1:0]        dv_q_ff   [0:QUO_W];
   side_type                     dv_side_ff[0:QUO_W];
   logic [NROOT_W-1:0]           cl_n_in;
   logic [2:0][DREM_W-1:0]       cl_r_in;
   logic [2:0][QUO_W-1:0]        cl_low_in;

   always_comb begin
      cl_n_in = NROOT_W'(sq_root_ff[ROOT_W]) + NROOT_W'(sq_rem_ff[ROOT_W] != '0);
      for (int i = 0; i < 3; i++) begin
         cl_r_in[i]   = DREM_W'(sq_side_ff[ROOT_W].num[i][NUM_W-1:QUO_W]);
         cl_low_in[i] = sq_side_ff[ROOT_W].num[i][QUO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_n_ff[0]    <= cl_n_in;
         dv_r_ff[0]    <= cl_r_in;
         dv_low_ff[0]  <= cl_low_in;
         dv_q_ff[0]    <= '0;
         dv_side_ff[0] <= sq_side_ff[ROOT_W];
      end
   end

   // restoring division by the rounded root, one quotient bit per stage
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [2:0][DREM_W:0]   t;
      logic [2:0][DREM_W-1:0] r_in;
      logic [2:0][QUO_W-1:0]  low_in, q_in;
      logic [2:0]             ge;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            t[i]  = {dv_r_ff[j][i], dv_low_ff[j][i][QUO_W-1]};
            ge[i] = t[i] >= {1'b0, dv_n_ff[j]};
            if (ge[i]) begin
               r_in[i] = DREM_W'(t[i] - {1'b0, dv_n_ff[j]});
            end else begin
               r_in[i] = t[i][DREM_W-1:0];
            end
            low_in[i] = {dv_low_ff[j][i][QUO_W-2:0], 1'b0};
            q_in[i]   = {dv_q_ff[j][i][QUO_W-2:0], ge[i]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_n_ff[j+1]    <= dv_n_ff[j];
            dv_r_ff[j+1]    <= r_in;
            dv_low_ff[j+1]  <= low_in;
            dv_q_ff[j+1]    <= q_in;
            dv_side_ff[j+1] <= dv_side_ff[j];
         end
      end
   end

   // output stage: apply sign, add to current position, saturate
   logic [2:0][MAG_W-1:0]  fin_m;
   logic [2:0][OSUM_W-1:0] fin_sum;
   logic [2:0][OSUM_W-PW:0] fin_hi;
   logic [2:0][PW-1:0]     out_ff, out_in;
   side_type               fin_side;

   assign fin_side = dv_side_ff[QUO_W];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin_m[i] = fin_side.scale ? MAG_W'(dv_q_ff[QUO_W][i]) : fin_side.mag[i];
         if (fin_side.neg[i]) begin
            fin_sum[i] = {{(OSUM_W-PW){fin_side.cur[i][PW-1]}}, fin_side.cur[i]}
                         - OSUM_W'(fin_m[i]);
         end else begin
            fin_sum[i] = {{(OSUM_W-PW){fin_side.cur[i][PW-1]}}, fin_side.cur[i]}
                         + OSUM_W'(fin_m[i]);
         end
         fin_hi[i] = fin_sum[i][OSUM_W-1:PW-1];
         if ((&fin_hi[i]) || !(|fin_hi[i])) begin
            out_in[i] = fin_sum[i][PW-1:0];
         end else begin
            out_in[i] = {fin_sum[i][OSUM_W-1], {(PW-1){~fin_sum[i][OSUM_W-1]}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

   // scaling needs a nonzero divisor no smaller than any clamped axis
   logic scale_chk;
   assign scale_chk = dv_v_ff[0] && dv_side_ff[0].scale;

   `SSL3D_ASSERT_IMP(a_root_nonzero, scale_chk, dv_n_ff[0] != '0)
   `SSL3D_ASSERT_IMP(a_root_covers_x, scale_chk, NROOT_W'(dv_side_ff[0].mag[0]) <= dv_n_ff[0])
   // a held result blocks intake and freezes the output word
   `SSL3D_ASSERT_IMP(a_backpressure, rsp_valid && rsp_stall, req_stall)
   `SSL3D_ASSERT_NXT(a_freeze, out_v_ff && rsp_stall, $stable(out_ff))

endmodule

// ----- sim/tb_setpoint_step_limiter_3d_top.sv -----
// Testbench for the setpoint step limiter: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module tb_setpoint_step_limiter_3d_top;
   import ssl3d_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 100;
   localparam int MIN_REQUEST = 6554;

   typedef struct {
      logic signed [31:0] tx, ty, tz, cx, cy, cz;
      logic [23:0]        req;
   } setpoint_word_type;

   typedef struct {
      logic [31:0] x, y, z;
   } limited_word_type;

   // Predicts limited setpoints and checks what the block returns
   class setpoint_scoreboard_type;
      logic [23:0] dflt_limit;
      logic [30:0] norm_thresh;
      limited_word_type pending[$];
      int          errors;

      function new();
         dflt_limit  = DEFAULT_LIMIT_RST;
         norm_thresh = NORM_THRESHOLD_RST;
         errors      = 0;
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function logic [63:0] isqrt_ceil(logic [63:0] s);
         logic [63:0] r;
         logic [63:0] b;
         r = '0;
         for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= s) r = b;
         end
         if (r * r < s) r++;
         return r;
      endfunction

      function void note_word(setpoint_word_type w);
         longint      cur[3], d[3];
         logic [63:0] lim, thr, s, n, m;
         bit          over;
         limited_word_type e;
         cur[0] = longint'(w.cx); cur[1] = longint'(w.cy); cur[2] = longint'(w.cz);
         d[0] = sat32(longint'(w.tx) - cur[0]);
         d[1] = sat32(longint'(w.ty) - cur[1]);
         d[2] = sat32(longint'(w.tz) - cur[2]);
         lim = (w.req < 24'(MIN_REQUEST)) ? 64'(dflt_limit) : 64'(w.req);
         lim = lim * 2;
         thr = 64'(norm_thresh);
         over = 0;
         for (int i = 0; i < 3; i++)
            if ((d[i] < 0 ? -d[i] : d[i]) > thr) over = 1;
         if (!over) begin
            s = 0;
            for (int i = 0; i < 3; i++) s += d[i] * d[i];
            if (s > thr * thr) over = 1;
         end
         // per-axis clamp once the offset is long
         if (over)
            for (int i = 0; i < 3; i++)
               if ((d[i] < 0 ? -d[i] : d[i]) > lim) d[i] = d[i] > 0 ? lim : -lim;
         s = 0;
         for (int i = 0; i < 3; i++) s += d[i] * d[i];
         // scale down to at most the limit, truncating toward zero
         if (s > lim * lim) begin
            n = isqrt_ceil(s);
            for (int i = 0; i < 3; i++) begin
               m = (d[i] < 0 ? -d[i] : d[i]) * lim / n;
               d[i] = d[i] < 0 ? -longint'(m) : longint'(m);
            end
         end
         e.x = 32'(sat32(cur[0] + d[0]));
         e.y = 32'(sat32(cur[1] + d[1]));
         e.z = 32'(sat32(cur[2] + d[2]));
         pending.push_back(e);
      endfunction

      function void check_word(limited_word_type a);
         limited_word_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word x=%h y=%h z=%h", $time, a.x, a.y, a.z);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.x !== e.x) begin
            $display("%0t: out_x expected %h actual %h", $time, e.x, a.x);
            errors++;
         end
         if (a.y !== e.y) begin
            $display("%0t: out_y expected %h actual %h", $time, e.y, a.y);
            errors++;
         end
         if (a.z !== e.z) begin
            $display("%0t: out_z expected %h actual %h", $time, e.z, a.z);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_target_x = 0, req_target_y = 0, req_target_z = 0;
   logic [31:0] req_current_x = 0, req_current_y = 0, req_current_z = 0;
   logic [23:0] req_requested_limit = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic        csr_we = 0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DEFAULT_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;

   setpoint_scoreboard_type sb = new();
   int  cycles = 0;
   bit  hold_off = 0;

   always #5 clock = ~clock;

   setpoint_step_limiter_3d_top DUT (.*);

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL setpoint_step_limiter_3d_top");
         $finish;
      end
   end

   // result sampling
   always @(posedge clock) begin
      limited_word_type a;
      if (!reset && rsp_valid && !rsp_stall) begin
         a.x = rsp_out_x; a.y = rsp_out_y; a.z = rsp_out_z;
         sb.check_word(a);
      end
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int mode;
      forever begin
         @(negedge clock);
         mode = (cycles / 500) % 3;
         if (hold_off) rsp_stall <= 1;
         else if (mode == 0) rsp_stall <= 0;
         else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   task automatic write_reg(csr_index_type idx, logic [30:0] val);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      if (idx == CSR_DEFAULT_LIMIT) sb.dflt_limit = val[23:0];
      else sb.norm_thresh = val;
   endtask

   task automatic wait_idle();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // offers one word and waits for acceptance; leaves valid high
   task automatic send_word(setpoint_word_type w);
      req_valid <= 1;
      req_target_x <= w.tx; req_target_y <= w.ty; req_target_z <= w.tz;
      req_current_x <= w.cx; req_current_y <= w.cy; req_current_z <= w.cz;
      req_requested_limit <= w.req;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
      @(negedge clock);
   endtask

   task automatic gap(int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2: return 32'($signed($urandom_range(0, 4000000)) - 2000000);
         default: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
      endcase
   endfunction

   function automatic setpoint_word_type rand_word();
      setpoint_word_type w;
      w.cx = rand_pos(); w.cy = rand_pos(); w.cz = rand_pos();
      // targets mostly near the current position
      if ($urandom_range(0, 2) == 0) begin
         w.tx = rand_pos(); w.ty = rand_pos(); w.tz = rand_pos();
      end else begin
         w.tx = w.cx + 32'($signed($urandom_range(0, 6000000)) - 3000000);
         w.ty = w.cy + 32'($signed($urandom_range(0, 6000000)) - 3000000);
         w.tz = w.cz + 32'($signed($urandom_range(0, 6000000)) - 3000000);
      end
      case ($urandom_range(0, 4))
         0: w.req = 24'($urandom());
         1: w.req = 24'($urandom_range(6550, 6558));
         2: w.req = 24'($urandom_range(0, 6553));
         default: w.req = 24'($urandom_range(0, 1000000));
      endcase
      return w;
   endfunction

   function automatic setpoint_word_type mk(logic [31:0] t, logic [31:0] c, logic [23:0] r);
      setpoint_word_type w;
      w.tx = t; w.ty = t; w.tz = t; w.cx = c; w.cy = c; w.cz = c; w.req = r;
      return w;
   endfunction

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         for (int i = 0; i < burst && count > 0; i++, count--) send_word(rand_word());
         gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
      end
      gap(1);
   endtask

   initial begin
      setpoint_word_type w;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, zero offset, default-limit threshold, clamp and scale
      send_word(mk(32'h7fffffff, 32'h80000000, 24'hffffff));
      send_word(mk(32'h80000000, 32'h7fffffff, 24'd0));
      send_word(mk(32'h0, 32'h0, 24'd6553));
      send_word(mk(32'h00010000, 32'h0, 24'd6554));
      send_word(mk(32'hffff0000, 32'h0, 24'd6555));
      w = mk(32'h0, 32'h0, 24'd65536); w.tx = 32'h00150000; send_word(w);
      w = mk(32'h0, 32'h0, 24'd65536); w.tx = 32'h000c0000; w.ty = 32'h000c0000;
      send_word(w);
      w = mk(32'h0, 32'h0, 24'd0); w.tx = 32'h00030000; w.tz = 32'hfffc0000;
      send_word(w);
      w = mk(32'h7fff0000, 32'h7ffffff0, 24'hffffff); w.tz = 32'h80000000; send_word(w);
      send_word(mk(32'h12345678, 32'hedcba987, 24'h800000));
      gap(1);

      // zero default limit with zero threshold
      wait_idle();
      write_reg(CSR_DEFAULT_LIMIT, 31'd0);
      write_reg(CSR_NORM_THRESHOLD, 31'd0);
      send_word(mk(32'h00001000, 32'h0, 24'd0));
      send_word(mk(32'h0, 32'h0, 24'd0));
      random_phase(60);

      // largest settings
      wait_idle();
      write_reg(CSR_DEFAULT_LIMIT, 31'hffffff);
      write_reg(CSR_NORM_THRESHOLD, 31'h7fffffff);
      send_word(mk(32'h7fffffff, 32'h80000000, 24'd0));
      random_phase(80);

      // long receiver hold-off while words keep coming
      hold_off = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         random_phase(100);
      join

      // mid-range settings
      wait_idle();
      write_reg(CSR_DEFAULT_LIMIT, 31'($urandom_range(1000, 2000000)));
      write_reg(CSR_NORM_THRESHOLD, 31'($urandom_range(0, 5000000)));
      random_phase(80);

      wait_idle();
      write_reg(CSR_DEFAULT_LIMIT, 31'($urandom()));
      write_reg(CSR_NORM_THRESHOLD, 31'($urandom()));
      random_phase(80);

      wait_idle();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS setpoint_step_limiter_3d_top");
      else
         $display("FAIL setpoint_step_limiter_3d_top");
      $finish;
   end

endmodule
